// ===== rtl/core/gcc_pkg.sv =====
package gcc_pkg;

  // field widths
  localparam int unsigned ByteW  = 8;
  localparam int unsigned AvgW   = 17;
  localparam int unsigned LenW   = 19;
  localparam int unsigned MinW   = AvgW - 2;
  localparam int unsigned HashW  = 32;
  localparam int unsigned GearN  = 256;

  // average chunk length after reset
  localparam logic [AvgW-1:0] AvgReset = 17'd8192;

  // gear table generator constants
  localparam logic [HashW-1:0] GearSeed = 32'h27D4EB2F;
  localparam logic [HashW-1:0] GearMult = 32'd2246822519;

  typedef logic [HashW-1:0] gear_rom_t [GearN];

  // thresholds derived from the average chunk length
  typedef struct packed {
    logic [MinW-1:0] min_len;
    logic [LenW-1:0] max_len;
    logic [AvgW-1:0] mask;
  } cfg_t;

  // xorshift-multiply sequence, evaluated at elaboration
  function automatic gear_rom_t build_gear_rom();
    logic [HashW-1:0] s;
    gear_rom_t        rom;
    s = GearSeed;
    for (int k = 0; k < GearN; k++) begin
      s = s ^ (s >> 15);
      s = s * GearMult;
      s = s ^ (s >> 13);
      rom[k] = s;
    end
    return rom;
  endfunction

  localparam gear_rom_t GearRom = build_gear_rom();

  // min = avg/4, max = avg*4, mask = low ones covering avg (at least one bit)
  function automatic cfg_t derive_cfg(logic [AvgW-1:0] avg);
    logic [AvgW-1:0] m1;
    cfg_t            c;
    c.min_len = avg[AvgW-1:2];
    c.max_len = {avg, 2'b00};
    m1 = avg - 17'd1;
    for (int i = 0; i < AvgW; i++) begin
      c.mask[i] = |(m1 >> i);
    end
    // zero average wraps the decrement: fall back to a one-bit mask
    if (avg == '0) begin
      c.mask = 17'd1;
    end
    c.mask[0] = 1'b1;
    return c;
  endfunction

endpackage

// ===== rtl/core/gcc_cfg.sv =====
module gcc_cfg (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [gcc_pkg::AvgW-1:0]  cfg_data_i,
  output gcc_pkg::cfg_t             cfg_o
);

  gcc_pkg::cfg_t cfg_d, cfg_q;

  // register writes are always taken
  assign cfg_ready_o = 1'b1;

  // derive thresholds once per write
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      cfg_d = gcc_pkg::derive_cfg(cfg_data_i);
    end
  end

  // threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= gcc_pkg::derive_cfg(gcc_pkg::AvgReset);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/core/gcc_hash.sv =====
module gcc_hash (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      advance_i,
  input  logic [gcc_pkg::ByteW-1:0] data_byte_i,
  input  logic                      last_byte_i,
  input  gcc_pkg::cfg_t             cfg_i,
  output logic                      chunk_end_o,
  output logic [gcc_pkg::LenW-1:0]  chunk_length_o
);

  logic [gcc_pkg::HashW-1:0] hash_d, hash_q;
  logic [gcc_pkg::LenW-1:0]  run_d, run_q;
  logic [gcc_pkg::HashW-1:0] hash_new;
  logic [gcc_pkg::LenW-1:0]  len;
  logic                      at_min;
  logic                      at_max;
  logic                      cut_point;
  logic                      chunk_end;

  // gear update: shift and add the table word
  assign hash_new = {hash_q[gcc_pkg::HashW-2:0], 1'b0} + gcc_pkg::GearRom[data_byte_i];
  assign len      = run_q + 19'd1;

  // boundary decision
  assign at_min    = len >= {4'b0000, cfg_i.min_len};
  assign at_max    = len >= cfg_i.max_len;
  assign cut_point = (hash_new[gcc_pkg::AvgW-1:0] & cfg_i.mask) == '0;
  assign chunk_end = last_byte_i || at_max || (at_min && cut_point);

  // state update when the request moves on
  always_comb begin
    hash_d = hash_q;
    run_d  = run_q;
    if (advance_i) begin
      if (chunk_end) begin
        hash_d = '0;
        run_d  = '0;
      end else begin
        hash_d = hash_new;
        run_d  = len;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= '0;
      run_q  <= '0;
    end else begin
      hash_q <= hash_d;
      run_q  <= run_d;
    end
  end

  assign chunk_end_o    = chunk_end;
  assign chunk_length_o = len;

  // a closed chunk leaves clean state
  a_clear_on_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && chunk_end |=> run_q == '0 && hash_q == '0)
    else $error("state not cleared after chunk end");

  // an open chunk keeps its running length
  a_len_carry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && !chunk_end |=> run_q == $past(len))
    else $error("run length lost");

  // the open length always stays below the maximum
  a_run_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i |=> run_q < cfg_i.max_len || run_q == '0)
    else $error("open chunk reached maximum length");

endmodule

// ===== rtl/core/gear_cdc_chunker.sv =====
// Streaming content-defined chunker on a 32-bit gear hash. Every accepted byte
// comes back out unchanged with chunk_end_o and chunk_length_o (bytes in the
// open chunk, this one included). A chunk ends at avg*4 bytes, at avg/4 bytes
// or more once the low hash bits under the boundary mask are zero, or on a
// byte flagged last. Throughput is one byte per clock: an input register feeds
// one stage of table lookup, shift-add and compares into the output register,
// and a result is offered once its byte has moved on into the output register;
// only a stall from the receiver slows it. Write the average length only while
// no request is in flight.
module gear_cdc_chunker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [gcc_pkg::ByteW-1:0] data_byte_i,
  input  logic                      last_byte_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [gcc_pkg::ByteW-1:0] byte_out_o,
  output logic                      chunk_end_o,
  output logic [gcc_pkg::LenW-1:0]  chunk_length_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [gcc_pkg::AvgW-1:0]  cfg_data_i
);

  gcc_pkg::cfg_t cfg;

  logic                      s1_valid_d, s1_valid_q;
  logic [gcc_pkg::ByteW-1:0] s1_byte_q;
  logic                      s1_last_q;
  logic                      out_valid_d, out_valid_q;
  logic [gcc_pkg::ByteW-1:0] out_byte_q;
  logic                      out_end_q;
  logic [gcc_pkg::LenW-1:0]  out_len_q;
  logic                      out_free;
  logic                      move;
  logic                      in_take;
  logic                      core_end;
  logic [gcc_pkg::LenW-1:0]  core_len;

  gcc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  gcc_hash u_hash (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .advance_i      (move),
    .data_byte_i    (s1_byte_q),
    .last_byte_i    (s1_last_q),
    .cfg_i          (cfg),
    .chunk_end_o    (core_end),
    .chunk_length_o (core_len)
  );

  // pipeline flow
  assign out_free   = !out_valid_q || !out_stall_i;
  assign move       = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  assign s1_valid_d  = in_take || (s1_valid_q && !move);
  assign out_valid_d = move || (out_valid_q && out_stall_i);

  // valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_byte_q <= data_byte_i;
      s1_last_q <= last_byte_i;
    end
    if (move) begin
      out_byte_q <= s1_byte_q;
      out_end_q  <= core_end;
      out_len_q  <= core_len;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign byte_out_o     = out_byte_q;
  assign chunk_end_o    = out_end_q;
  assign chunk_length_o = out_len_q;

endmodule

// ===== bench/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ByteW = gcc_pkg::ByteW;
  localparam int unsigned AvgW  = gcc_pkg::AvgW;
  localparam int unsigned LenW  = gcc_pkg::LenW;
  localparam int unsigned HashW = gcc_pkg::HashW;
  localparam int unsigned GearN = gcc_pkg::GearN;
  localparam logic [AvgW-1:0]  AvgReset = gcc_pkg::AvgReset;
  localparam logic [HashW-1:0] GearSeed = gcc_pkg::GearSeed;
  localparam logic [HashW-1:0] GearMult = gcc_pkg::GearMult;

  localparam int unsigned LongHold  = 300;
  localparam int unsigned IdleLimit = 5000;
  localparam int unsigned MaxReport = 40;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             is_last;
  } byte_req_t;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             is_end;
    logic [LenW-1:0]  len;
  } chunk_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic             in_valid = 1'b0;
  wire              in_stall;
  logic [ByteW-1:0] data_byte = '0;
  logic             last_byte = 1'b0;
  wire              out_valid;
  logic             out_stall = 1'b0;
  wire [ByteW-1:0]  byte_out;
  wire              chunk_end;
  wire [LenW-1:0]   chunk_length;
  logic             cfg_valid = 1'b0;
  wire              cfg_ready;
  logic [AvgW-1:0]  cfg_data = '0;

  // predictor state
  logic [HashW-1:0] gear_tbl [GearN];
  logic [HashW-1:0] gear_hash = '0;
  logic [LenW-1:0]  open_len = '0;
  logic [AvgW-1:0]  avg_model = AvgReset;

  byte_req_t  byte_queue [$];
  chunk_res_t chunk_expect [$];
  byte_req_t  next_req;
  chunk_res_t got_res;
  chunk_res_t want_res;

  logic        gaps_on = 1'b1;
  int unsigned tx_wait = 0;
  int unsigned rx_wait = 0;
  int unsigned rx_hold = 0;
  int unsigned hold_token = 0;
  int unsigned hold_seen = 0;
  int unsigned idle_cycles = 0;

  int unsigned errors = 0;
  int unsigned bytes_fed = 0;
  int unsigned results_seen = 0;
  int unsigned chunks_closed = 0;
  int unsigned avg_writes = 0;

  gear_cdc_chunker u_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .data_byte_i   (data_byte),
    .last_byte_i   (last_byte),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .byte_out_o    (byte_out),
    .chunk_end_o   (chunk_end),
    .chunk_length_o(chunk_length),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_data_i    (cfg_data)
  );

  always #1 clk = ~clk;

  // gear hash step plus boundary decision for one byte
  function automatic chunk_res_t predict_chunk(input logic [ByteW-1:0] b, input logic lst);
    logic [31:0]     avg32;
    logic [31:0]     min_len;
    logic [31:0]     max_len;
    logic [31:0]     mask;
    logic [LenW-1:0] len;
    int unsigned     bits;
    logic            hit;
    chunk_res_t      r;
    avg32   = 32'(avg_model);
    min_len = avg32 >> 2;
    max_len = avg32 << 2;
    bits = 1;
    while (bits < 31 && (32'd1 << bits) < avg32) bits++;
    mask = (32'd1 << bits) - 32'd1;
    gear_hash = (gear_hash << 1) + gear_tbl[b];
    len = open_len + 1'b1;
    hit = lst || (32'(len) >= max_len) ||
          (32'(len) >= min_len && (gear_hash & mask) == '0);
    r.data   = b;
    r.is_end = hit;
    r.len    = len;
    if (hit) begin
      gear_hash = '0;
      open_len  = '0;
    end else begin
      open_len = len;
    end
    return r;
  endfunction

  function automatic void report_field(input string name, input int unsigned want,
                                       input int unsigned got);
    if (want != got) begin
      errors++;
      if (errors <= MaxReport) begin
        $error("%s mismatch: expected %0d, got %0d", name, want, got);
      end
    end
  endfunction

  // input driver: config capture, prediction on accept, next request
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        avg_model = cfg_data;
        avg_writes++;
      end
      if (in_valid && !in_stall) begin
        chunk_expect.insert(chunk_expect.size(), predict_chunk(data_byte, last_byte));
        bytes_fed++;
      end
      if (!in_valid || !in_stall) begin
        if (tx_wait > 0) begin
          tx_wait--;
          in_valid <= 1'b0;
        end else if (byte_queue.size() > 0) begin
          next_req = byte_queue[0];
          byte_queue.delete(0);
          data_byte <= next_req.data;
          last_byte <= next_req.is_last;
          in_valid  <= 1'b1;
          tx_wait = gaps_on ? $urandom_range(0, 4) : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output monitor and receiver stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        got_res.data   = byte_out;
        got_res.is_end = chunk_end;
        got_res.len    = chunk_length;
        if (got_res.is_end) chunks_closed++;
        if (chunk_expect.size() == 0) begin
          errors++;
          $error("result with no pending request: byte_out %0d", byte_out);
        end else begin
          want_res = chunk_expect[0];
          chunk_expect.delete(0);
          report_field("byte_out", want_res.data, got_res.data);
          report_field("chunk_end", want_res.is_end, got_res.is_end);
          report_field("chunk_length", want_res.len, got_res.len);
        end
        rx_wait = gaps_on ? $urandom_range(0, 4) : 0;
      end
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        rx_hold   = LongHold;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_stall <= 1'b1;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("watchdog: no request moved for %0d cycles", idle_cycles);
      $display("FAILED: results differ");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic wait_idle();
    while (byte_queue.size() != 0 || in_valid || chunk_expect.size() != 0) @(negedge clk);
    // pipeline is two deep, leave some margin
    repeat (4) @(posedge clk);
  endtask

  task automatic write_avg(input logic [AvgW-1:0] v);
    wait_idle();
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic push_byte(input logic [ByteW-1:0] b, input logic lst);
    byte_req_t r;
    r.data    = b;
    r.is_last = lst;
    byte_queue.insert(byte_queue.size(), r);
  endtask

  // well-formed stream: random bytes closed by a last flag
  task automatic push_stream(input int unsigned n);
    for (int i = 0; i < n; i++) push_byte(ByteW'($urandom), i == n - 1);
  endtask

  // noise: random bytes with a stray last flag now and then
  task automatic push_noise(input int unsigned n);
    for (int i = 0; i < n; i++) push_byte(ByteW'($urandom), $urandom_range(0, 7) == 0);
  endtask

  initial begin
    logic [HashW-1:0] s;
    logic [AvgW-1:0]  avg;
    int unsigned      n;
    int unsigned      len;

    // gear table from the xorshift-multiply generator
    s = GearSeed;
    for (int k = 0; k < GearN; k++) begin
      s = s ^ (s >> 15);
      s = s * GearMult;
      s = s ^ (s >> 13);
      gear_tbl[k] = s;
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset average: byte extremes, last flag ends a chunk, single-byte chunk
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h80, 1'b1);
    push_byte(8'h7F, 1'b1);

    // zero average: every byte closes its own chunk
    write_avg('0);
    push_byte(8'h01, 1'b0);
    push_byte(8'hFE, 1'b0);

    // tiny averages, maximum length reached quickly
    write_avg(17'd1);
    push_byte(8'hAA, 1'b0);
    push_byte(8'h55, 1'b0);
    push_byte(8'h0F, 1'b0);
    write_avg(17'd2);
    for (int i = 0; i < 9; i++) push_byte(8'h00, 1'b0);

    // largest average, only the last flag can end the chunk
    write_avg(17'h1FFFF);
    push_byte(8'h12, 1'b0);
    push_byte(8'h34, 1'b0);
    push_byte(8'h56, 1'b1);

    // open a chunk, then shrink the maximum to its open length
    write_avg(17'd65536);
    for (int i = 0; i < 4; i++) push_byte(ByteW'($urandom), 1'b0);
    write_avg(17'd1);
    push_byte(8'hC3, 1'b0);

    // random phases, each under its own average
    for (int p = 0; p < 16; p++) begin
      case ($urandom_range(0, 5))
        0:       avg = AvgW'($urandom_range(0, 131071));
        1:       avg = AvgW'($urandom_range(0, 3));
        default: avg = AvgW'($urandom_range(4, 96));
      endcase
      if (p == 0) avg = 17'h1FFFF;
      if (p == 1) avg = '0;
      write_avg(avg);
      gaps_on <= (p % 4 != 1);
      n = 0;
      while (n < 90) begin
        len = $urandom_range(1, 60);
        if ($urandom_range(0, 4) == 0) push_noise(len);
        else push_stream(len);
        n += len;
      end
      // long receiver hold while the sender keeps offering
      if (p == 3) hold_token <= hold_token + 1;
    end

    wait_idle();
    $display("fed %0d bytes, %0d results, %0d chunk ends, %0d average writes",
             bytes_fed, results_seen, chunks_closed, avg_writes);
    $display("averages from 0 to 131071 with sender gaps, receiver stalls and one long hold");
    if (errors == 0 && chunk_expect.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
